### sv/yuvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_pkg: shared types and constants of the packed 4:2:2 to planar 4:2:0
// converter.
// Register indexes, field widths and the words passed between the stages.
// ----------------------------------------------------------------------------
package yuvc_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W   = 13;
    localparam int SIZE_W  = 14;
    localparam int LUMA_W  = 24;
    localparam int CHROMA_W = 25;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 112;

    typedef enum logic [2:0] {
        REG_PIXEL_FORMAT  = 3'd0,
        REG_SOURCE_WIDTH  = 3'd1,
        REG_SOURCE_HEIGHT = 3'd2,
        REG_OUT_WIDTH     = 3'd3,
        REG_OUT_HEIGHT    = 3'd4
    } reg_index_t;

    typedef enum logic {
        FMT_YUYV = 1'b0,
        FMT_UYVY = 1'b1
    } pixel_format_t;

    typedef struct packed {
        pixel_format_t         fmt;
        logic [SIZE_W-1:0]     src_pairs;
        logic [SIZE_W-1:0]     src_height;
        logic [SIZE_W-1:0]     out_pairs;
        logic [SIZE_W-1:0]     out_height;
        logic [CHROMA_W-1:0]   u_base;
        logic [CHROMA_W-1:0]   v_base;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic                  keep;
        logic                  even;
        logic                  last;
        logic [LUMA_W-1:0]     luma_pos;
        logic [CHROMA_W-1:0]   chroma_pos;
        logic [IN_W-1:0]       data;
    } stage_t;

endpackage
`default_nettype wire

### sv/yuvc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_cfg: configuration registers.
// Holds the APB registers and derives the clamped frame sizes and the plane
// base offsets from them over three registered steps. Input is held off while
// the derived values settle after a reset or a write to a defined register.
// ----------------------------------------------------------------------------
module yuvc_cfg #(
    parameter int MAX_WIDTH  = yuvc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = yuvc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [yuvc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [yuvc_pkg::DATA_W-1:0]  pwdata,
    output logic      [yuvc_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic                              restart,
    output logic                              busy,
    output yuvc_pkg::cfg_t                    cfg
);

    localparam int SW = yuvc_pkg::SIZE_W;
    localparam int CW = yuvc_pkg::CFG_W;

    yuvc_pkg::reg_index_t  index;
    logic                  wr;
    logic                  fmt_reg;
    logic [CW-1:0]         src_w_reg, src_h_reg, out_w_reg, out_h_reg;
    logic [SW-1:0]         sw, sh, ow, oh, ow_reg;
    logic [SW-1:0]         src_pairs_reg, out_pairs_reg, sh_reg, oh_reg;
    logic [yuvc_pkg::AREA_W-1:0] area_reg;
    logic [yuvc_pkg::AREA_W:0]   v_sum;
    logic [yuvc_pkg::CHROMA_W-1:0] u_base_reg, v_base_reg;
    logic [1:0]            settle_reg;

    assign index  = yuvc_pkg::reg_index_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        restart = 1'b0;
        if (wr) begin
            unique case (index)
                yuvc_pkg::REG_PIXEL_FORMAT, yuvc_pkg::REG_SOURCE_WIDTH,
                yuvc_pkg::REG_SOURCE_HEIGHT, yuvc_pkg::REG_OUT_WIDTH,
                yuvc_pkg::REG_OUT_HEIGHT: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= 1'b0;
            src_w_reg <= CW'(640);
            src_h_reg <= CW'(480);
            out_w_reg <= CW'(640);
            out_h_reg <= CW'(480);
        end else if (wr) begin
            unique case (index)
                yuvc_pkg::REG_PIXEL_FORMAT:  fmt_reg   <= pwdata[0];
                yuvc_pkg::REG_SOURCE_WIDTH:  src_w_reg <= pwdata[CW-1:0];
                yuvc_pkg::REG_SOURCE_HEIGHT: src_h_reg <= pwdata[CW-1:0];
                yuvc_pkg::REG_OUT_WIDTH:     out_w_reg <= pwdata[CW-1:0];
                yuvc_pkg::REG_OUT_HEIGHT:    out_h_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            settle_reg <= 2'd2;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    assign busy = (settle_reg != 2'd0);

    always_comb begin
        unique case (index)
            yuvc_pkg::REG_PIXEL_FORMAT:  prdata = yuvc_pkg::DATA_W'(fmt_reg);
            yuvc_pkg::REG_SOURCE_WIDTH:  prdata = yuvc_pkg::DATA_W'(src_w_reg);
            yuvc_pkg::REG_SOURCE_HEIGHT: prdata = yuvc_pkg::DATA_W'(src_h_reg);
            yuvc_pkg::REG_OUT_WIDTH:     prdata = yuvc_pkg::DATA_W'(out_w_reg);
            yuvc_pkg::REG_OUT_HEIGHT:    prdata = yuvc_pkg::DATA_W'(out_h_reg);
            default:                     prdata = '0;
        endcase
    end

    // Clamp the sizes; the output crop never exceeds the source frame.
    always_comb begin
        sw = SW'(src_w_reg);
        if (sw < SW'(2))
            sw = SW'(2);
        else if (sw > SW'(MAX_WIDTH))
            sw = SW'(MAX_WIDTH);
        sw[0] = 1'b0;

        sh = SW'(src_h_reg);
        if (sh < SW'(2))
            sh = SW'(2);
        else if (sh > SW'(MAX_HEIGHT))
            sh = SW'(MAX_HEIGHT);

        ow = SW'(out_w_reg);
        if (ow < SW'(2))
            ow = SW'(2);
        else if (ow > sw)
            ow = sw;
        ow[0] = 1'b0;

        oh = SW'(out_h_reg);
        if (oh < SW'(2))
            oh = SW'(2);
        else if (oh > sh)
            oh = sh;
        oh[0] = 1'b0;
    end

    assign v_sum = (yuvc_pkg::AREA_W+1)'(area_reg)
                 + (yuvc_pkg::AREA_W+1)'(area_reg >> 2);

    always_ff @(posedge aclk) begin
        src_pairs_reg <= sw >> 1;
        out_pairs_reg <= ow >> 1;
        sh_reg        <= sh;
        oh_reg        <= oh;
        ow_reg        <= ow;
        area_reg      <= yuvc_pkg::AREA_W'(ow_reg) * yuvc_pkg::AREA_W'(oh_reg);
        u_base_reg    <= area_reg[yuvc_pkg::CHROMA_W-1:0];
        v_base_reg    <= v_sum[yuvc_pkg::CHROMA_W-1:0];
    end

    always_comb begin
        cfg.fmt        = yuvc_pkg::pixel_format_t'(fmt_reg);
        cfg.src_pairs  = src_pairs_reg;
        cfg.src_height = sh_reg;
        cfg.out_pairs  = out_pairs_reg;
        cfg.out_height = oh_reg;
        cfg.u_base     = u_base_reg;
        cfg.v_base     = v_base_reg;
    end

endmodule
`default_nettype wire

### sv/yuvc_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_track: input register and raster position tracking.
// Registers each accepted word together with its crop decision and its luma
// and chroma positions, and steps the column and row counters.
// ----------------------------------------------------------------------------
module yuvc_track #(
    parameter int MAX_WIDTH  = yuvc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = yuvc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [yuvc_pkg::IN_W-1:0]   s_tdata,
    input  wire logic                        restart,
    input  wire logic                        cfg_busy,
    input  wire yuvc_pkg::cfg_t              cfg,
    input  wire logic                        out_ready,
    output yuvc_pkg::stage_t                 stage
);

    localparam int COL_W = $clog2(MAX_WIDTH / 2 + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = yuvc_pkg::SIZE_W;

    logic [COL_W-1:0]              col_reg, col_next, col_inc;
    logic [ROW_W-1:0]              row_reg, row_next, row_inc;
    logic [yuvc_pkg::LUMA_W-1:0]   luma_reg, luma_next;
    logic [yuvc_pkg::CHROMA_W-1:0] chroma_reg, chroma_next;
    logic                          keep, even, last, accept;
    yuvc_pkg::stage_t              stage_reg;

    assign s_tready = (!stage_reg.valid || out_ready) && !cfg_busy;
    assign accept   = s_tvalid && s_tready;
    assign col_inc  = col_reg + COL_W'(1);
    assign row_inc  = row_reg + ROW_W'(1);
    assign keep     = (SW'(col_reg) < cfg.out_pairs) && (SW'(row_reg) < cfg.out_height);
    assign even     = !row_reg[0];
    assign last     = (SW'(row_reg) == cfg.out_height - SW'(1))
                   && (SW'(col_reg) == cfg.out_pairs - SW'(1));

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        luma_next   = luma_reg;
        chroma_next = chroma_reg;
        if (restart) begin
            col_next    = '0;
            row_next    = '0;
            luma_next   = '0;
            chroma_next = '0;
        end else if (accept) begin
            if (keep) begin
                luma_next = luma_reg + yuvc_pkg::LUMA_W'(2);
                if (even)
                    chroma_next = chroma_reg + yuvc_pkg::CHROMA_W'(1);
            end
            col_next = col_inc;
            if (SW'(col_inc) >= cfg.src_pairs) begin
                col_next = '0;
                row_next = row_inc;
                if (SW'(row_inc) >= cfg.src_height) begin
                    row_next    = '0;
                    luma_next   = '0;
                    chroma_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            luma_reg   <= '0;
            chroma_reg <= '0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            luma_reg   <= luma_next;
            chroma_reg <= chroma_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (accept) begin
            stage_reg.valid <= 1'b1;
        end else if (out_ready) begin
            stage_reg.valid <= 1'b0;
        end
        if (accept) begin
            stage_reg.keep       <= keep;
            stage_reg.even       <= even;
            stage_reg.last       <= last;
            stage_reg.luma_pos   <= luma_reg;
            stage_reg.chroma_pos <= chroma_reg;
            stage_reg.data       <= s_tdata;
        end
    end

    assign stage = stage_reg;

endmodule
`default_nettype wire

### sv/yuvc_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_out: result register.
// Sorts the macropixel bytes into luma and chroma, adds the plane bases to
// the chroma position and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module yuvc_out (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire yuvc_pkg::stage_t             stage,
    input  wire yuvc_pkg::cfg_t               cfg,
    output logic                              out_ready,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [yuvc_pkg::OUT_W-1:0]        m_tdata,
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast
);

    localparam int CH = yuvc_pkg::CHROMA_W;

    logic [7:0]    y0, y1, u, v;
    logic [CH-1:0] u_off, v_off;
    logic          valid_reg, load;
    logic [yuvc_pkg::OUT_W-1:0] data_reg, data_next;
    logic          chroma_reg, last_reg;

    assign out_ready = !valid_reg || m_tready;
    assign load      = out_ready && stage.valid && stage.keep;

    always_comb begin
        if (cfg.fmt == yuvc_pkg::FMT_YUYV) begin
            y0 = stage.data[7:0];
            u  = stage.data[15:8];
            y1 = stage.data[23:16];
            v  = stage.data[31:24];
        end else begin
            u  = stage.data[7:0];
            y0 = stage.data[15:8];
            v  = stage.data[23:16];
            y1 = stage.data[31:24];
        end
        u_off = cfg.u_base + stage.chroma_pos;
        v_off = cfg.v_base + stage.chroma_pos;
        if (!stage.even) begin
            u     = '0;
            v     = '0;
            u_off = '0;
            v_off = '0;
        end
        data_next = {6'b0, v, u, v_off, u_off, y1, y0, stage.luma_pos};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= stage.valid && stage.keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg   <= data_next;
            chroma_reg <= stage.even;
            last_reg   <= stage.last;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = chroma_reg;
    assign m_tlast    = last_reg;

endmodule
`default_nettype wire

### sv/packed_yuv422_to_planar_yuv420.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_yuv422_to_planar_yuv420: packed 4:2:2 to planar 4:2:0 converter.
// Crops a YUYV or UYVY frame and emits luma and even-row chroma bytes with
// their offsets in a planar 4:2:0 buffer.
// ----------------------------------------------------------------------------
// The block takes one macropixel word in every clock cycle while the result
// register does not stall it and the configuration is not settling. Each word
// passes through the input register, where the crop decision and raster
// positions are fixed, and then the result register, where the plane offsets
// are added. Words outside the crop give no result. A write to any defined
// register restarts the frame; the derived sizes and plane bases then settle
// through the width clamp, the area multiplier and the base adder, so s_tready
// is held low after such a write and after reset until they are in place.
module packed_yuv422_to_planar_yuv420 #(
    parameter int MAX_WIDTH  = yuvc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = yuvc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [yuvc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [yuvc_pkg::DATA_W-1:0]  pwdata,
    output logic      [yuvc_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // byte0, byte1, byte2, byte3
    input  wire logic [yuvc_pkg::IN_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // luma_offset, luma_first, luma_second, u_offset, v_offset, u_value,
    // v_value, zero fill
    output logic [yuvc_pkg::OUT_W-1:0]        m_tdata,
    // chroma_write
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast
);

    yuvc_pkg::cfg_t   cfg;
    yuvc_pkg::stage_t stage;
    logic             restart;
    logic             cfg_busy;
    logic             out_ready;

    yuvc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .restart (restart),
        .busy    (cfg_busy),
        .cfg     (cfg)
    );

    yuvc_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .restart   (restart),
        .cfg_busy  (cfg_busy),
        .cfg       (cfg),
        .out_ready (out_ready),
        .stage     (stage)
    );

    yuvc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage     (stage),
        .cfg       (cfg),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        stage.valid && !out_ready |-> !s_tready)
        else $error("input accepted while the input register is stalled");

    a_settle_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_busy |-> !s_tready)
        else $error("input accepted while the frame sizes are settling");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !stage.valid |=> !m_tvalid)
        else $error("result word repeated after it was taken");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !stage.valid)
        else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for packed_yuv422_to_planar_yuv420
// Sends macropixel words under a run of crop and format settings, predicts
// every planar word from its own model of the frame counters and plane
// offsets, and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [23:0] luma_offset;
        logic [7:0]  luma_first;
        logic [7:0]  luma_second;
        logic        chroma_write;
        logic [24:0] u_offset;
        logic [24:0] v_offset;
        logic [7:0]  u_value;
        logic [7:0]  v_value;
        logic        frame_end;
    } planar_word_t;

    class planar_scoreboard;
        yuvc_pkg::pixel_format_t fmt;
        logic [12:0]   src_w, src_h, out_w, out_h;
        int unsigned   col, row, luma_pos, chroma_pos;
        planar_word_t  due_words[$];
        int unsigned   mismatches, words_in, words_out, chroma_words, frame_ends;

        function new();
            fmt = yuvc_pkg::FMT_YUYV;
            src_w = 13'd640;
            src_h = 13'd480;
            out_w = 13'd640;
            out_h = 13'd480;
            restart();
        endfunction

        function void restart();
            col = 0;
            row = 0;
            luma_pos = 0;
            chroma_pos = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(logic [2:0] index, logic [31:0] value);
            case (index)
                yuvc_pkg::REG_PIXEL_FORMAT:  fmt = yuvc_pkg::pixel_format_t'(value[0]);
                yuvc_pkg::REG_SOURCE_WIDTH:  src_w = value[12:0];
                yuvc_pkg::REG_SOURCE_HEIGHT: src_h = value[12:0];
                yuvc_pkg::REG_OUT_WIDTH:     out_w = value[12:0];
                yuvc_pkg::REG_OUT_HEIGHT:    out_h = value[12:0];
                default:                     return;
            endcase
            restart();
        endfunction

        function void take_macropixel(logic [31:0] word);
            int unsigned  sw, sh, ow, oh, src_pairs, out_pairs, area;
            logic [7:0]   y0, y1, u, v;
            planar_word_t w;
            sw = clamp_size(src_w, 2, yuvc_pkg::DEF_MAX_WIDTH) & ~32'd1;
            sh = clamp_size(src_h, 2, yuvc_pkg::DEF_MAX_HEIGHT);
            ow = clamp_size(out_w, 2, sw) & ~32'd1;
            oh = clamp_size(out_h, 2, sh) & ~32'd1;
            src_pairs = sw / 2;
            out_pairs = ow / 2;
            words_in++;
            if (fmt == yuvc_pkg::FMT_YUYV) begin
                y0 = word[7:0];
                u  = word[15:8];
                y1 = word[23:16];
                v  = word[31:24];
            end else begin
                u  = word[7:0];
                y0 = word[15:8];
                v  = word[23:16];
                y1 = word[31:24];
            end
            if (col >= src_pairs || row >= sh)
                restart();
            if (col < out_pairs && row < oh) begin
                area = ow * oh;
                w.luma_offset = luma_pos[23:0];
                w.luma_first = y0;
                w.luma_second = y1;
                if (row[0] == 1'b0) begin
                    w.chroma_write = 1'b1;
                    w.u_offset = 25'(area + chroma_pos);
                    w.v_offset = 25'(area + area / 4 + chroma_pos);
                    w.u_value = u;
                    w.v_value = v;
                    chroma_pos++;
                end else begin
                    w.chroma_write = 1'b0;
                    w.u_offset = '0;
                    w.v_offset = '0;
                    w.u_value = '0;
                    w.v_value = '0;
                end
                w.frame_end = (row == oh - 1) && (col == out_pairs - 1);
                luma_pos += 2;
                due_words.push_back(w);
            end
            col++;
            if (col >= src_pairs) begin
                col = 0;
                row++;
                if (row >= sh)
                    restart();
            end
        endfunction

        function void compare(string name, logic [31:0] expv, logic [31:0] actv);
            if (actv !== expv) begin
                $error("%s: expected %0d, got %0d", name, expv, actv);
                mismatches++;
            end
        endfunction

        function void check_planar_word(logic [111:0] data, logic chroma, logic last);
            planar_word_t w;
            if (due_words.size() == 0) begin
                $error("planar word %h arrived with none expected", data);
                mismatches++;
                return;
            end
            w = due_words.pop_front();
            words_out++;
            if (w.chroma_write)
                chroma_words++;
            if (w.frame_end)
                frame_ends++;
            compare("luma_offset", w.luma_offset, data[23:0]);
            compare("luma_first", w.luma_first, data[31:24]);
            compare("luma_second", w.luma_second, data[39:32]);
            compare("u_offset", w.u_offset, data[64:40]);
            compare("v_offset", w.v_offset, data[89:65]);
            compare("u_value", w.u_value, data[97:90]);
            compare("v_value", w.v_value, data[105:98]);
            compare("chroma_write", w.chroma_write, chroma);
            compare("frame_end", w.frame_end, last);
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [yuvc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [yuvc_pkg::DATA_W-1:0]   pwdata = '0;
    logic [yuvc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [yuvc_pkg::IN_W-1:0]     s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [yuvc_pkg::OUT_W-1:0]    m_tdata;
    logic [0:0]                    m_tuser;
    logic                          m_tlast;

    planar_scoreboard sb = new();
    int unsigned      sent_words = 0;
    int unsigned      settings = 0;
    bit               rx_calm = 1'b0;

    packed_yuv422_to_planar_yuv420 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_planar_word(m_tdata, m_tuser[0], m_tlast);
            if (s_tvalid && s_tready)
                sb.take_macropixel(s_tdata);
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_word(logic [31:0] word, int unsigned gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_words++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic apb_write(logic [2:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(index, value);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(yuvc_pkg::pixel_format_t fmt, logic [12:0] sw,
                             logic [12:0] sh, logic [12:0] ow, logic [12:0] oh);
        wait_idle();
        apb_write(yuvc_pkg::REG_PIXEL_FORMAT, {31'd0, fmt});
        apb_write(yuvc_pkg::REG_SOURCE_WIDTH, {19'd0, sw});
        apb_write(yuvc_pkg::REG_SOURCE_HEIGHT, {19'd0, sh});
        apb_write(yuvc_pkg::REG_OUT_WIDTH, {19'd0, ow});
        apb_write(yuvc_pkg::REG_OUT_HEIGHT, {19'd0, oh});
        repeat (4) @(negedge aclk);
        settings++;
    endtask

    function automatic logic [12:0] draw_size();
        case ($urandom_range(0, 19))
            0:       return 13'($urandom_range(0, 1));
            1:       return 13'd4096;
            2:       return 13'd8191;
            3:       return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(2, 14));
        endcase
    endfunction

    initial begin
        #(12 * 500000);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        wait (aresetn);
        @(negedge aclk);
        forever begin
            int unsigned gap;
            gap = rx_calm ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    initial begin
        bit          burst;
        int unsigned n;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: full 640 x 480 frame.
        send_word(32'h0000_0000, 0);
        send_word(32'hFFFF_FFFF, 3);
        send_word(32'h7F80_01FE, 0);

        // Crop in both directions, an odd source height and a frame wrap.
        configure(yuvc_pkg::FMT_YUYV, 13'd6, 13'd3, 13'd4, 13'd2);
        repeat (11) send_word($urandom, $urandom_range(0, 2));

        // Every size saturated; a write to an unused register keeps the frame going.
        configure(yuvc_pkg::FMT_UYVY, 13'd1, 13'd0, 13'd8191, 13'd1);
        send_word(32'hFF00_FF00, 0);
        send_word(32'h00FF_00FF, 1);
        send_word($urandom, 0);
        wait_idle();
        apb_write(3'd6, 32'h0000_1FFF);
        send_word($urandom, 0);

        // Largest frame, so the plane offsets reach their top bits.
        configure(yuvc_pkg::FMT_YUYV, 13'd4096, 13'd8191, 13'd8191, 13'd4096);
        repeat (40) send_word($urandom, $urandom_range(0, 11));

        while (sent_words < 1450) begin
            configure(yuvc_pkg::pixel_format_t'($urandom_range(0, 1)), draw_size(),
                      draw_size(), draw_size(), draw_size());
            if ($urandom_range(0, 4) == 0)
                apb_write(3'($urandom_range(5, 7)), $urandom);
            burst = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 120);
            repeat (n) send_word($urandom, burst ? 0 : $urandom_range(0, 11));
        end

        s_tvalid <= 1'b0;
        for (int i = 0; i < 2000 && sb.due_words.size() != 0; i++)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (sb.due_words.size() != 0) begin
            $error("%0d planar words never arrived", sb.due_words.size());
            sb.mismatches++;
        end

        $display("Sent %0d macropixel words under %0d size and format settings.",
                 sent_words, settings);
        $display("Checked %0d planar words: %0d with chroma, %0d closing a frame.",
                 sb.words_out, sb.chroma_words, sb.frame_ends);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### filelist.f
sv/yuvc_pkg.sv
sv/yuvc_cfg.sv
sv/yuvc_track.sv
sv/yuvc_out.sv
sv/packed_yuv422_to_planar_yuv420.sv
tb/testbench.sv
